@@ rtl/core/burst_pulse_width_qualifier_unit_macros.svh @@
// assertion macros shared by the burst pulse width qualifier rtl
// no dependencies; included by the files that carry assertions
`ifndef BURST_PULSE_WIDTH_QUALIFIER_UNIT_MACROS_SVH
`define BURST_PULSE_WIDTH_QUALIFIER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BPWQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpwq assertion failed");

// next-cycle implication, disabled while in reset
`define BPWQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpwq assertion failed");

`endif

@@ rtl/core/bpwq_pkg.sv @@
// types and constants for the burst pulse width qualifier
// no dependencies; used by every module of the block
`default_nettype none

package bpwq_pkg;

   localparam int unsigned TickWidth  = 10;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 10;

   localparam logic [CountWidth-1:0] HitsMax = 4'd15;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrTimeoutTicks = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrWidthMin     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrWidthMax     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrWindowLength = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrHitThreshold = 3'd4;

   // reset values
   localparam logic [TickWidth-1:0]  RstTimeoutTicks = 10'd300;
   localparam logic [TickWidth-1:0]  RstWidthMin     = 10'd60;
   localparam logic [TickWidth-1:0]  RstWidthMax     = 10'd61;
   localparam logic [CountWidth-1:0] RstWindowLength = 4'd10;
   localparam logic [CountWidth-1:0] RstHitThreshold = 4'd5;

   typedef struct packed {
      logic burst_level;
      logic start_req;
   } req_type;

   typedef struct packed {
      logic [TickWidth-1:0]  pulse_width;
      logic                  width_ok;
      logic [CountWidth-1:0] hit_count;
      logic                  window_done;
      logic                  detected;
   } rsp_type;

   typedef struct packed {
      logic [TickWidth-1:0]  timeout_ticks;
      logic [TickWidth-1:0]  width_min;
      logic [TickWidth-1:0]  width_max;
      logic [CountWidth-1:0] window_length;
      logic [CountWidth-1:0] hit_threshold;
   } cfg_type;

   // result handed from the tracker to the response buffer
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_WAIT_LOW  = 4'b0010,
      PH_WAIT_HIGH = 4'b0100,
      PH_MEASURE   = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

@@ rtl/core/bpwq_csr_regs.sv @@
// configuration registers of the burst pulse width qualifier
// depends on bpwq_pkg
`default_nettype none

module bpwq_csr_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [bpwq_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [bpwq_pkg::CsrDataWidth-1:0]    csr_wdata,
   output bpwq_pkg::cfg_type                         cfg
);

   bpwq_pkg::cfg_type cfg_ff;
   bpwq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpwq_pkg::CsrTimeoutTicks: cfg_in.timeout_ticks = csr_wdata;
            bpwq_pkg::CsrWidthMin:     cfg_in.width_min     = csr_wdata;
            bpwq_pkg::CsrWidthMax:     cfg_in.width_max     = csr_wdata;
            bpwq_pkg::CsrWindowLength:
               cfg_in.window_length = csr_wdata[bpwq_pkg::CountWidth-1:0];
            bpwq_pkg::CsrHitThreshold:
               cfg_in.hit_threshold = csr_wdata[bpwq_pkg::CountWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= bpwq_pkg::RstTimeoutTicks;
         cfg_ff.width_min     <= bpwq_pkg::RstWidthMin;
         cfg_ff.width_max     <= bpwq_pkg::RstWidthMax;
         cfg_ff.window_length <= bpwq_pkg::RstWindowLength;
         cfg_ff.hit_threshold <= bpwq_pkg::RstHitThreshold;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/bpwq_tracker.sv @@
// phase tracker: measures one pulse per measurement and qualifies it
// depends on bpwq_pkg and the block macro header
`default_nettype none
`include "burst_pulse_width_qualifier_unit_macros.svh"

module bpwq_tracker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire bpwq_pkg::req_type req,
   input  wire bpwq_pkg::cfg_type cfg,
   output bpwq_pkg::result_type result
);

   localparam int unsigned TW = bpwq_pkg::TickWidth;
   localparam int unsigned CW = bpwq_pkg::CountWidth;

   bpwq_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic [CW-1:0] index_ff, index_in;
   logic [CW-1:0] hits_ff, hits_in;

   logic [TW-1:0] tmo;
   logic [TW:0]   next_ticks;
   logic          next_timeout;
   logic [CW-1:0] win_len;
   logic          fin;
   logic [TW-1:0] fin_width;
   logic          width_ok;
   logic [CW-1:0] hits_new;
   logic [CW-1:0] index_new;
   logic          done;

   // zero timeout and zero window length behave as one
   assign tmo = (cfg.timeout_ticks == '0) ? TW'(1) : cfg.timeout_ticks;
   assign win_len = (cfg.window_length == '0) ? CW'(1) : cfg.window_length;
   assign next_ticks = {1'b0, elapsed_ff} + (TW+1)'(1);
   assign next_timeout = next_ticks >= {1'b0, tmo};

   always_comb begin
      fin = 1'b0;
      fin_width = '0;
      phase_in = phase_ff;
      elapsed_in = elapsed_ff;
      index_in = index_ff;
      hits_in = hits_ff;
      if (accept) begin
         if (req.start_req) begin
            phase_in = bpwq_pkg::PH_WAIT_LOW;
            elapsed_in = '0;
            index_in = '0;
            hits_in = '0;
         end else begin
            unique case (phase_ff)
               bpwq_pkg::PH_IDLE: ;
               bpwq_pkg::PH_WAIT_LOW: begin
                  if (!req.burst_level || next_timeout) begin
                     phase_in = bpwq_pkg::PH_WAIT_HIGH;
                     elapsed_in = '0;
                  end else begin
                     elapsed_in = next_ticks[TW-1:0];
                  end
               end
               bpwq_pkg::PH_WAIT_HIGH: begin
                  if (req.burst_level) begin
                     // the rising tick already counts as high time
                     if (tmo == TW'(1)) begin
                        fin = 1'b1;
                        fin_width = tmo;
                     end else begin
                        phase_in = bpwq_pkg::PH_MEASURE;
                        elapsed_in = TW'(1);
                     end
                  end else if (next_timeout) begin
                     fin = 1'b1;
                     fin_width = '0;
                  end else begin
                     elapsed_in = next_ticks[TW-1:0];
                  end
               end
               bpwq_pkg::PH_MEASURE: begin
                  if (!req.burst_level) begin
                     fin = 1'b1;
                     fin_width = elapsed_ff;
                  end else if (next_timeout) begin
                     fin = 1'b1;
                     fin_width = tmo;
                  end else begin
                     elapsed_in = next_ticks[TW-1:0];
                  end
               end
               default: ;
            endcase
         end
         if (fin) begin
            hits_in = hits_new;
            elapsed_in = '0;
            if (done) begin
               phase_in = bpwq_pkg::PH_IDLE;
               index_in = '0;
            end else begin
               phase_in = bpwq_pkg::PH_WAIT_LOW;
               index_in = index_new;
            end
         end
      end
   end

   assign width_ok = (fin_width >= cfg.width_min) && (fin_width <= cfg.width_max);
   assign hits_new = (width_ok && (hits_ff != bpwq_pkg::HitsMax)) ?
                     hits_ff + CW'(1) : hits_ff;
   assign index_new = index_ff + CW'(1);
   assign done = index_new >= win_len;

   always_comb begin
      result.valid = fin;
      result.data.pulse_width = fin_width;
      result.data.width_ok = width_ok;
      result.data.hit_count = hits_new;
      result.data.window_done = done;
      result.data.detected = done && (hits_new >= cfg.hit_threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bpwq_pkg::PH_IDLE;
         elapsed_ff <= '0;
         index_ff <= '0;
         hits_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         elapsed_ff <= elapsed_in;
         index_ff <= index_in;
         hits_ff <= hits_in;
      end
   end

   // idle always leaves the counters cleared
   `BPWQ_ASSERT_IMPL(a_idle_clear, clock, reset, phase_ff == bpwq_pkg::PH_IDLE,
                     elapsed_ff == '0 && index_ff == '0)
   // a finished window returns the tracker to idle
   `BPWQ_ASSERT_NEXT(a_done_idle, clock, reset, result.valid && result.data.window_done,
                     phase_ff == bpwq_pkg::PH_IDLE)
   // no result comes from a tick that was not taken
   `BPWQ_ASSERT_IMPL(a_result_accept, clock, reset, result.valid, accept && !req.start_req)

endmodule

`default_nettype wire

@@ rtl/core/bpwq_rsp_buffer.sv @@
// response output register with a one-entry skid stage
// depends on bpwq_pkg and the block macro header
`default_nettype none
`include "burst_pulse_width_qualifier_unit_macros.svh"

module bpwq_rsp_buffer (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bpwq_pkg::result_type result,
   output logic               busy,
   output logic               rsp_valid,
   input  wire logic           rsp_stall,
   output bpwq_pkg::rsp_type  rsp_data
);

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   bpwq_pkg::rsp_type out_ff, out_in;
   bpwq_pkg::rsp_type skid_ff, skid_in;
   logic out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in = out_ff;
      skid_in = skid_ff;
      if (out_free) begin
         // skid drains first; no new item is taken while it is full
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in = result.data;
            out_valid_in = result.valid;
         end
      end else if (result.valid) begin
         skid_in = result.data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign busy = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   `BPWQ_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `BPWQ_ASSERT_NEXT(a_skid_fill, clock, reset, result.valid && out_valid_ff && rsp_stall,
                     skid_valid_ff)
   `BPWQ_ASSERT_IMPL(a_no_overrun, clock, reset, skid_valid_ff, !result.valid)

endmodule

`default_nettype wire

@@ rtl/core/burst_pulse_width_qualifier_unit.sv @@
// Burst pulse width qualifier, top level.
// Input channel (req_): one item per microsecond tick carrying the sampled
// burst line level and a start flag. A start opens a window of
// window_length pulse measurements and gives no result itself.
// Result channel (rsp_): one item per finished measurement with the
// width, its hit flag, the running hit count, and on the last measurement
// of the window window_done and detected.
// Throughput: one tick per clock while req_stall is low; the phase tracker updates all its
// counters in the cycle the tick is taken.
// Output: each result passes through the output register before it is on rsp_.
// Stall: the output register plus a one-entry skid keep taking ticks
// while a result waits; req_stall rises only once the skid holds a result.
// Reset: synchronous; the registers return to their defaults, the tracker
// goes idle with cleared counts and both result stages empty.
// Configuration (csr_): write only while no window is running.
// depends on bpwq_pkg, bpwq_csr_regs, bpwq_tracker, bpwq_rsp_buffer
`default_nettype none

module burst_pulse_width_qualifier_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bpwq_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bpwq_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [bpwq_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [bpwq_pkg::CsrDataWidth-1:0] csr_wdata
);

   bpwq_pkg::cfg_type    cfg;
   bpwq_pkg::result_type result;
   logic                 busy;
   logic                 accept;

   assign req_stall = busy;
   assign accept = req_valid && !busy;

   bpwq_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpwq_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .result (result)
   );

   bpwq_rsp_buffer u_rsp (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
